[design/rit_pkg.sv]
// package for the reference-counted identity table
// holds field widths, opcodes, status codes, default sizes and the scan control structs
// no dependencies
`timescale 1ns / 1ps

package rit_pkg;

	localparam int TABLE_DEPTH_DEF    = 64;
	localparam int REFERENCE_BITS_DEF = 16;

	localparam int OP_W     = 2;
	localparam int MOUNT_W  = 8;
	localparam int NUMBER_W = 64;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int HELD_W   = 7;
	localparam int TOTAL_W  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE = 2'd0,
		OP_HOLD    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_HIT        = 3'd0,
		STS_ALLOCATED  = 3'd1,
		STS_NO_FREE    = 3'd2,
		STS_READ_FAIL  = 3'd3,
		STS_STILL_HELD = 3'd4,
		STS_FREED      = 3'd5,
		STS_REFUSED    = 3'd6,
		STS_HELD       = 3'd7
	} status_t;

	typedef struct packed {
		logic clear;
		logic eval;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic have_free;
	} scan_stat_t;

endpackage

[design/rit_store.sv]
// entry memory of the identity table: one row per slot (valid, mount, number, count)
// one write port and one registered read port
// depends on rit_pkg for the key widths
`timescale 1ns / 1ps

module rit_store #(
	parameter int TABLE_DEPTH    = rit_pkg::TABLE_DEPTH_DEF,
	parameter int REFERENCE_BITS = rit_pkg::REFERENCE_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]                       wr_addr,
	input  logic [rit_pkg::MOUNT_W+rit_pkg::NUMBER_W+REFERENCE_BITS:0] wr_row,
	input  logic [$clog2(TABLE_DEPTH)-1:0]                       rd_addr,
	output logic [rit_pkg::MOUNT_W+rit_pkg::NUMBER_W+REFERENCE_BITS:0] rd_row
);

	localparam int ROW_W = 1 + rit_pkg::MOUNT_W + rit_pkg::NUMBER_W + REFERENCE_BITS;

	logic [ROW_W-1:0] mem_q [TABLE_DEPTH];
	logic [ROW_W-1:0] rd_row_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		rd_row_q <= mem_q[rd_addr];
	end

	assign rd_row = rd_row_q;

endmodule

[design/rit_scan.sv]
// key compare unit, used once per slot while an acquire walks the table
// remembers the first matching valid slot and the lowest free slot
// depends on rit_pkg for key widths and the control structs
`timescale 1ns / 1ps

module rit_scan #(
	parameter int TABLE_DEPTH    = rit_pkg::TABLE_DEPTH_DEF,
	parameter int REFERENCE_BITS = rit_pkg::REFERENCE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rit_pkg::scan_ctl_t                  ctl,
	input  logic [$clog2(TABLE_DEPTH)-1:0]      eval_addr,
	input  logic                                row_valid,
	input  logic [rit_pkg::MOUNT_W-1:0]         row_mount,
	input  logic [rit_pkg::NUMBER_W-1:0]        row_number,
	input  logic [REFERENCE_BITS-1:0]           row_refs,
	input  logic [rit_pkg::MOUNT_W-1:0]         key_mount,
	input  logic [rit_pkg::NUMBER_W-1:0]        key_number,
	output rit_pkg::scan_stat_t                 stat,
	output logic [$clog2(TABLE_DEPTH)-1:0]      hit_addr,
	output logic [$clog2(TABLE_DEPTH)-1:0]      free_addr,
	output logic [REFERENCE_BITS-1:0]           hit_refs
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                hit_q;
	logic                have_free_q;
	logic [AW-1:0]       hit_addr_q;
	logic [AW-1:0]       free_addr_q;
	logic [REFERENCE_BITS-1:0] hit_refs_q;
	logic                match;

	assign match = row_valid && (row_mount == key_mount) && (row_number == key_number);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
		end else if (ctl.eval && !hit_q) begin
			if (match) begin
				hit_q <= 1'b1;
			end else if (!row_valid) begin
				have_free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval && !ctl.clear && !hit_q) begin
			if (match) begin
				hit_addr_q <= eval_addr;
				hit_refs_q <= row_refs;
			end else if (!row_valid && !have_free_q) begin
				free_addr_q <= eval_addr;
			end
		end
	end

	assign stat.hit       = hit_q;
	assign stat.have_free = have_free_q;
	assign hit_addr       = hit_addr_q;
	assign free_addr      = free_addr_q;
	assign hit_refs       = hit_refs_q;

endmodule

[design/refcounted_identity_table_unit.sv]
// reference-counted identity table, top level: sequencer, counters and result register
// instantiates rit_store (entry memory) and rit_scan (key compare unit); uses rit_pkg
//
// usage:
//  - request channel: in_valid/in_stall with op, mount_id, file_number, slot_index, read_ok;
//    a request is taken when in_valid is high and in_stall is low
//  - result channel: out_valid/out_stall with status, result_slot, reference_count,
//    held_entries, hit_total and fill_total; one result per request, in order
//  - one request at a time; in_stall stays high from acceptance until the result is
//    placed in the output register, so no new request is taken before then
//  - acquire: the compare unit walks the table one slot per cycle through the single
//    memory read port, and stops early when the key is found
//  - hold and release: read, update, write back; the unused opcode is refused with no write
//  - the output register frees the block for the next request while a result waits;
//    a result that finds the register still full waits until out_stall drops
//  - after reset the table is cleared one slot per cycle while in_stall is high;
//    all counts start at zero
`timescale 1ns / 1ps

module refcounted_identity_table_unit #(
	parameter int TABLE_DEPTH    = rit_pkg::TABLE_DEPTH_DEF,
	parameter int REFERENCE_BITS = rit_pkg::REFERENCE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rit_pkg::OP_W-1:0]     op,
	input  logic [rit_pkg::MOUNT_W-1:0]  mount_id,
	input  logic [rit_pkg::NUMBER_W-1:0] file_number,
	input  logic [rit_pkg::SLOT_W-1:0]   slot_index,
	input  logic                         read_ok,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rit_pkg::STATUS_W-1:0] status,
	output logic [rit_pkg::SLOT_W-1:0]   result_slot,
	output logic [rit_pkg::COUNT_W-1:0]  reference_count,
	output logic [rit_pkg::HELD_W-1:0]   held_entries,
	output logic [rit_pkg::TOTAL_W-1:0]  hit_total,
	output logic [rit_pkg::TOTAL_W-1:0]  fill_total
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RB    = REFERENCE_BITS;
	localparam int ROW_W = 1 + rit_pkg::MOUNT_W + rit_pkg::NUMBER_W + RB;
	localparam int XW    = (AW > rit_pkg::SLOT_W) ? AW : rit_pkg::SLOT_W;
	localparam int RXW   = (RB > rit_pkg::COUNT_W) ? RB : rit_pkg::COUNT_W;
	localparam int VXW   = (CNT_W > rit_pkg::HELD_W) ? CNT_W : rit_pkg::HELD_W;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_LOOKUP = 7'b0000100,
		S_EXEC   = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	function automatic logic [rit_pkg::SLOT_W-1:0] to_slot(input logic [AW-1:0] a);
		logic [XW-1:0] t;
		t = XW'(a);
		return t[rit_pkg::SLOT_W-1:0];
	endfunction

	function automatic logic [rit_pkg::COUNT_W-1:0] to_count(input logic [RB-1:0] r);
		logic [RXW-1:0] t;
		t = RXW'(r);
		return t[rit_pkg::COUNT_W-1:0];
	endfunction

	function automatic logic [rit_pkg::HELD_W-1:0] to_held(input logic [CNT_W-1:0] v);
		logic [VXW-1:0] t;
		t = VXW'(v);
		return t[rit_pkg::HELD_W-1:0];
	endfunction

	// saturating increment
	function automatic logic [RB-1:0] bump(input logic [RB-1:0] r);
		return (&r) ? r : r + 1'b1;
	endfunction

	state_t                       state_q, state_d;
	logic [CNT_W-1:0]             cnt_q;
	logic                         eval_s1;
	logic [AW-1:0]                eval_addr_s1;

	rit_pkg::op_t                 op_q;
	logic [rit_pkg::MOUNT_W-1:0]  mount_q;
	logic [rit_pkg::NUMBER_W-1:0] number_q;
	logic [rit_pkg::SLOT_W-1:0]   slot_q;
	logic                         read_ok_q;

	logic [CNT_W-1:0]             valid_count_q;
	logic [rit_pkg::TOTAL_W-1:0]  hit_q, fill_q;

	rit_pkg::status_t             res_status_q, res_status_d;
	logic [rit_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
	logic [RB-1:0]                res_count_q, res_count_d;

	logic                         out_valid_q;
	logic [rit_pkg::STATUS_W-1:0] out_status_q;
	logic [rit_pkg::SLOT_W-1:0]   out_slot_q;
	logic [rit_pkg::COUNT_W-1:0]  out_count_q;
	logic [rit_pkg::HELD_W-1:0]   out_held_q;
	logic [rit_pkg::TOTAL_W-1:0]  out_hit_q, out_fill_q;

	logic                         accept, out_load, res_load;
	logic                         vc_inc, vc_dec, hit_inc, fill_inc;

	logic                         wr_en;
	logic [AW-1:0]                wr_addr, rd_addr;
	logic [ROW_W-1:0]             wr_row, rd_row;

	logic                         rd_valid;
	logic [rit_pkg::MOUNT_W-1:0]  rd_mount;
	logic [rit_pkg::NUMBER_W-1:0] rd_number;
	logic [RB-1:0]                rd_refs;
	logic [RB-1:0]                refs_new;

	logic [XW-1:0]                slot_x;
	logic [AW-1:0]                slot_addr;
	logic                         slot_ok;

	rit_pkg::scan_ctl_t           scan_ctl;
	rit_pkg::scan_stat_t          scan_stat;
	logic [AW-1:0]                hit_addr, free_addr;
	logic [RB-1:0]                hit_refs;

	assign rd_valid  = rd_row[ROW_W-1];
	assign rd_mount  = rd_row[ROW_W-2 -: rit_pkg::MOUNT_W];
	assign rd_number = rd_row[RB +: rit_pkg::NUMBER_W];
	assign rd_refs   = rd_row[RB-1:0];

	assign slot_x    = XW'(slot_q);
	assign slot_addr = slot_x[AW-1:0];
	assign slot_ok   = {1'b0, slot_x} < (XW+1)'(TABLE_DEPTH);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign rd_addr  = (state_q == S_SCAN) ? cnt_q[AW-1:0] : slot_addr;

	assign scan_ctl.clear = accept && (rit_pkg::op_t'(op) == rit_pkg::OP_ACQUIRE);
	assign scan_ctl.eval  = eval_s1 && (state_q == S_SCAN);

	rit_store #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.REFERENCE_BITS (REFERENCE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	rit_scan #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.REFERENCE_BITS (REFERENCE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.eval_addr  (eval_addr_s1),
		.row_valid  (rd_valid),
		.row_mount  (rd_mount),
		.row_number (rd_number),
		.row_refs   (rd_refs),
		.key_mount  (mount_q),
		.key_number (number_q),
		.stat       (scan_stat),
		.hit_addr   (hit_addr),
		.free_addr  (free_addr),
		.hit_refs   (hit_refs)
	);

	always_comb begin
		state_d      = state_q;
		wr_en        = 1'b0;
		wr_addr      = slot_addr;
		wr_row       = '0;
		res_load     = 1'b0;
		res_status_d = rit_pkg::STS_REFUSED;
		res_slot_d   = '0;
		res_count_d  = '0;
		refs_new     = '0;
		vc_inc       = 1'b0;
		vc_dec       = 1'b0;
		hit_inc      = 1'b0;
		fill_inc     = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				if (cnt_q == CNT_W'(TABLE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (rit_pkg::op_t'(op) == rit_pkg::OP_ACQUIRE) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_LOOKUP;
					end
				end
			end
			S_LOOKUP: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				res_load = 1'b1;
				state_d  = S_RESP;
				unique case (op_q)
					rit_pkg::OP_HOLD: begin
						res_status_d = rit_pkg::STS_HELD;
						res_slot_d   = slot_q;
						if (slot_ok) begin
							refs_new    = bump(rd_refs);
							wr_en       = 1'b1;
							wr_row      = {rd_valid, rd_mount, rd_number, refs_new};
							res_count_d = refs_new;
						end
					end
					rit_pkg::OP_RELEASE: begin
						res_status_d = rit_pkg::STS_REFUSED;
						res_slot_d   = slot_q;
						if (slot_ok) begin
							res_count_d = rd_refs;
							if (rd_valid && (rd_refs != '0)) begin
								refs_new    = rd_refs - 1'b1;
								res_count_d = refs_new;
								wr_en       = 1'b1;
								if (refs_new != '0) begin
									res_status_d = rit_pkg::STS_STILL_HELD;
									wr_row = {1'b1, rd_mount, rd_number, refs_new};
								end else begin
									res_status_d = rit_pkg::STS_FREED;
									wr_row = {1'b0, rd_mount, rd_number, refs_new};
									vc_dec = 1'b1;
								end
							end
						end
					end
					default: begin
						res_status_d = rit_pkg::STS_REFUSED;
					end
				endcase
			end
			S_SCAN: begin
				if (scan_stat.hit || ((cnt_q == CNT_W'(TABLE_DEPTH)) && !eval_s1)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				res_load = 1'b1;
				state_d  = S_RESP;
				priority if (scan_stat.hit) begin
					refs_new     = bump(hit_refs);
					wr_en        = 1'b1;
					wr_addr      = hit_addr;
					wr_row       = {1'b1, mount_q, number_q, refs_new};
					hit_inc      = 1'b1;
					res_status_d = rit_pkg::STS_HIT;
					res_slot_d   = to_slot(hit_addr);
					res_count_d  = refs_new;
				end else if (!scan_stat.have_free) begin
					res_status_d = rit_pkg::STS_NO_FREE;
				end else if (read_ok_q) begin
					wr_en        = 1'b1;
					wr_addr      = free_addr;
					wr_row       = {1'b1, mount_q, number_q, RB'(1)};
					vc_inc       = 1'b1;
					fill_inc     = 1'b1;
					res_status_d = rit_pkg::STS_ALLOCATED;
					res_slot_d   = to_slot(free_addr);
					res_count_d  = RB'(1);
				end else begin
					// claimed and released again, count back to zero
					wr_en        = 1'b1;
					wr_addr      = free_addr;
					wr_row       = {1'b0, mount_q, number_q, {RB{1'b0}}};
					res_status_d = rit_pkg::STS_READ_FAIL;
					res_slot_d   = to_slot(free_addr);
				end
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			eval_s1       <= 1'b0;
			valid_count_q <= '0;
			hit_q         <= '0;
			fill_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == S_SCAN) && (cnt_q != CNT_W'(TABLE_DEPTH));
			if (state_q == S_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (accept) begin
				cnt_q <= '0;
			end else if ((state_q == S_SCAN) && (cnt_q != CNT_W'(TABLE_DEPTH))) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (vc_inc) begin
				valid_count_q <= valid_count_q + 1'b1;
			end else if (vc_dec) begin
				valid_count_q <= valid_count_q - 1'b1;
			end
			if (hit_inc) begin
				hit_q <= hit_q + 1'b1;
			end
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		eval_addr_s1 <= cnt_q[AW-1:0];
		if (accept) begin
			op_q      <= rit_pkg::op_t'(op);
			mount_q   <= mount_id;
			number_q  <= file_number;
			slot_q    <= slot_index;
			read_ok_q <= read_ok;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_count_q  <= res_count_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_count_q  <= to_count(res_count_q);
			out_held_q   <= to_held(valid_count_q);
			out_hit_q    <= hit_q;
			out_fill_q   <= fill_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign result_slot     = out_slot_q;
	assign reference_count = out_count_q;
	assign held_entries    = out_held_q;
	assign hit_total       = out_hit_q;
	assign fill_total      = out_fill_q;

endmodule

[test/refcounted_identity_table_unit_tb.sv]
// self-checking testbench for refcounted_identity_table_unit: directed, table fill,
// back-to-back holds and random lookup/hold/release traffic checked against a shadow table
// depends on rit_pkg and the design files under design/
`timescale 1ns / 1ps

module refcounted_identity_table_unit_tb;
	import rit_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int IDLE_PCT   = 21;
	localparam int SQUEEZE    = 300;
	localparam int BATCHES    = 40;
	localparam int BATCH_SIZE = 10;
	localparam int CALM_HOLDS = 24;

	typedef struct {
		op_t                 kind;
		logic [MOUNT_W-1:0]  mount;
		logic [NUMBER_W-1:0] number;
		logic [SLOT_W-1:0]   slot;
		logic                ok;
	} request_t;

	typedef struct {
		status_t             sts;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  refs;
		logic [HELD_W-1:0]   held;
		logic [TOTAL_W-1:0]  hits;
		logic [TOTAL_W-1:0]  fills;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = '0;
	logic [MOUNT_W-1:0] mount_id = '0;
	logic [NUMBER_W-1:0] file_number = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic read_ok = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] result_slot;
	logic [COUNT_W-1:0] reference_count;
	logic [HELD_W-1:0] held_entries;
	logic [TOTAL_W-1:0] hit_total;
	logic [TOTAL_W-1:0] fill_total;

	// shadow copy of the table
	logic                shadow_valid [DEPTH];
	logic                shadow_keyed [DEPTH];
	logic [MOUNT_W-1:0]  shadow_mount [DEPTH];
	logic [NUMBER_W-1:0] shadow_number [DEPTH];
	logic [COUNT_W-1:0]  shadow_refs [DEPTH];
	logic [HELD_W-1:0]   shadow_held = '0;
	logic [TOTAL_W-1:0]  shadow_hits = '0;
	logic [TOTAL_W-1:0]  shadow_fills = '0;

	request_t lookup_requests[$];
	outcome_t table_answers[$];
	request_t on_wire;
	outcome_t head;
	int failures = 0;
	logic calm = 1'b0;
	logic squeeze_go = 1'b0;
	logic squeeze_done;
	int squeeze_left;

	refcounted_identity_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.mount_id(mount_id),
		.file_number(file_number),
		.slot_index(slot_index),
		.read_ok(read_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_slot(result_slot),
		.reference_count(reference_count),
		.held_entries(held_entries),
		.hit_total(hit_total),
		.fill_total(fill_total)
	);

	always #10 clk = ~clk;

	function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// applies one request to the shadow table and returns the result it must produce
	function automatic outcome_t table_outcome(request_t r);
		outcome_t o;
		int hit_at;
		int free_at;
		hit_at = -1;
		free_at = -1;
		o.sts = STS_REFUSED;
		o.slot = '0;
		o.refs = '0;
		case (r.kind)
			OP_ACQUIRE: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (shadow_valid[i]) begin
						if (hit_at < 0 && shadow_mount[i] == r.mount && shadow_number[i] == r.number)
							hit_at = i;
					end else if (free_at < 0) begin
						free_at = i;
					end
				end
				if (hit_at >= 0) begin
					shadow_refs[hit_at] = bump(shadow_refs[hit_at]);
					shadow_hits++;
					o.sts = STS_HIT;
					o.slot = SLOT_W'(hit_at);
					o.refs = shadow_refs[hit_at];
				end else if (free_at < 0) begin
					o.sts = STS_NO_FREE;
				end else begin
					shadow_keyed[free_at] = 1'b1;
					shadow_mount[free_at] = r.mount;
					shadow_number[free_at] = r.number;
					o.slot = SLOT_W'(free_at);
					if (r.ok) begin
						shadow_valid[free_at] = 1'b1;
						shadow_refs[free_at] = COUNT_W'(1);
						shadow_held++;
						shadow_fills++;
						o.sts = STS_ALLOCATED;
						o.refs = COUNT_W'(1);
					end else begin
						// claimed slot goes straight back to free
						shadow_refs[free_at] = '0;
						o.sts = STS_READ_FAIL;
					end
				end
			end
			OP_HOLD: begin
				shadow_refs[r.slot] = bump(shadow_refs[r.slot]);
				o.sts = STS_HELD;
				o.slot = r.slot;
				o.refs = shadow_refs[r.slot];
			end
			OP_RELEASE: begin
				o.slot = r.slot;
				if (shadow_valid[r.slot] && shadow_refs[r.slot] != 0) begin
					shadow_refs[r.slot]--;
					if (shadow_refs[r.slot] != 0) begin
						o.sts = STS_STILL_HELD;
					end else begin
						shadow_valid[r.slot] = 1'b0;
						shadow_held--;
						o.sts = STS_FREED;
					end
				end
				o.refs = shadow_refs[r.slot];
			end
			default: ;
		endcase
		o.held = shadow_held;
		o.hits = shadow_hits;
		o.fills = shadow_fills;
		return o;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int known;
		int live;
		int pick;
		known = $urandom_range(DEPTH - 1);
		live = $urandom_range(DEPTH - 1);
		for (int k = 0; k < DEPTH && !shadow_keyed[known]; k++)
			known = (known + 1) % DEPTH;
		for (int k = 0; k < DEPTH && !shadow_valid[live]; k++)
			live = (live + 1) % DEPTH;
		r.kind = OP_ACQUIRE;
		r.mount = MOUNT_W'($urandom);
		r.number = {$urandom, $urandom};
		r.slot = SLOT_W'($urandom);
		r.ok = ($urandom_range(99) < 85);
		pick = $urandom_range(99);
		if (pick < 28 && shadow_keyed[known]) begin
			r.mount = shadow_mount[known];
			r.number = shadow_number[known];
		end else if (pick < 36 && shadow_keyed[known]) begin
			// key differs from a stored one in a single bit
			r.mount = shadow_mount[known];
			r.number = shadow_number[known];
			if ($urandom_range(1))
				r.mount[$urandom_range(MOUNT_W - 1)] ^= 1'b1;
			else
				r.number[$urandom_range(NUMBER_W - 1)] ^= 1'b1;
		end else if (pick >= 46 && pick < 96) begin
			r.kind = (pick < 56) ? OP_HOLD : OP_RELEASE;
			if ($urandom_range(3) != 0 && shadow_valid[live])
				r.slot = SLOT_W'(live);
		end else if (pick >= 96) begin
			r.kind = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic queue_request(op_t kind, logic [MOUNT_W-1:0] mount,
			logic [NUMBER_W-1:0] number, logic [SLOT_W-1:0] slot, logic ok);
		request_t r;
		r.kind = kind;
		r.mount = mount;
		r.number = number;
		r.slot = slot;
		r.ok = ok;
		lookup_requests.push_back(r);
	endtask

	task automatic queue_fresh_acquire(logic ok);
		queue_request(OP_ACQUIRE, MOUNT_W'($urandom), {$urandom, $urandom},
			SLOT_W'($urandom), ok);
	endtask

	task automatic drain();
		while (lookup_requests.size() != 0 || in_valid || table_answers.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_ACQUIRE;
			mount_id <= '0;
			file_number <= '0;
			slot_index <= '0;
			read_ok <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				table_answers.push_back(table_outcome(on_wire));
			if (lookup_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				on_wire = lookup_requests.pop_front();
				op <= on_wire.kind;
				mount_id <= on_wire.mount;
				file_number <= on_wire.number;
				slot_index <= on_wire.slot;
				read_ok <= on_wire.ok;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			squeeze_left <= 0;
			squeeze_done <= 1'b0;
		end else if (squeeze_go && !squeeze_done) begin
			squeeze_done <= 1'b1;
			squeeze_left <= SQUEEZE;
			out_stall <= 1'b1;
		end else if (squeeze_left != 0) begin
			squeeze_left <= squeeze_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (table_answers.size() == 0) begin
				$error("result with no request outstanding: status %0d slot %0d",
					status, result_slot);
				failures++;
			end else begin
				head = table_answers.pop_front();
				if (status !== head.sts) begin
					$error("status: expected %0d, got %0d", head.sts, status);
					failures++;
				end
				if (result_slot !== head.slot) begin
					$error("result_slot: expected %0d, got %0d", head.slot, result_slot);
					failures++;
				end
				if (reference_count !== head.refs) begin
					$error("reference_count: expected %0d, got %0d", head.refs, reference_count);
					failures++;
				end
				if (held_entries !== head.held) begin
					$error("held_entries: expected %0d, got %0d", head.held, held_entries);
					failures++;
				end
				if (hit_total !== head.hits) begin
					$error("hit_total: expected %0d, got %0d", head.hits, hit_total);
					failures++;
				end
				if (fill_total !== head.fills) begin
					$error("fill_total: expected %0d, got %0d", head.fills, fill_total);
					failures++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_keyed[i] = 1'b0;
			shadow_mount[i] = '0;
			shadow_number[i] = '0;
			shadow_refs[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: key extremes, hits, read failure, every release outcome, dead slot hold
		queue_request(OP_ACQUIRE, 8'h00, 64'h0, 6'd0, 1'b1);
		queue_request(OP_ACQUIRE, 8'h00, 64'h0, 6'd63, 1'b0);
		queue_request(OP_ACQUIRE, 8'hff, '1, 6'd0, 1'b1);
		queue_request(OP_ACQUIRE, 8'hff, 64'h0, 6'd0, 1'b0);
		queue_request(OP_ACQUIRE, 8'h00, '1, 6'd63, 1'b1);
		queue_request(OP_HOLD, 8'hff, '1, 6'd0, 1'b1);
		queue_request(OP_HOLD, 8'h00, 64'h0, 6'd63, 1'b0);
		queue_request(OP_HOLD, 8'h00, 64'h0, 6'd63, 1'b0);
		queue_request(OP_RELEASE, 8'h00, 64'h0, 6'd63, 1'b1);
		queue_request(OP_RELEASE, 8'h00, 64'h0, 6'd1, 1'b1);
		queue_request(OP_RELEASE, 8'h00, 64'h0, 6'd1, 1'b1);
		queue_request(OP_RELEASE, 8'hff, '1, 6'd0, 1'b0);
		queue_request(OP_UNUSED, 8'hff, '1, 6'd63, 1'b1);
		queue_request(OP_UNUSED, 8'h00, 64'h0, 6'd0, 1'b0);
		queue_request(OP_ACQUIRE, 8'haa, 64'haaaa_aaaa_aaaa_aaaa, 6'h15, 1'b1);
		queue_request(OP_ACQUIRE, 8'h55, 64'h5555_5555_5555_5555, 6'h2a, 1'b1);
		queue_request(OP_ACQUIRE, 8'h01, 64'h1, 6'd5, 1'b0);
		queue_request(OP_RELEASE, 8'h01, 64'h1, 6'd4, 1'b1);
		queue_request(OP_ACQUIRE, 8'h00, 64'h0, 6'd0, 1'b1);
		queue_request(OP_ACQUIRE, 8'haa, 64'haaaa_aaaa_aaaa_aaaa, 6'd0, 1'b0);
		drain();

		// fill every slot, then try to claim one more
		while (shadow_held < DEPTH) begin
			for (int k = shadow_held; k < DEPTH; k++)
				queue_fresh_acquire(1'b1);
			drain();
		end
		queue_fresh_acquire(1'b1);
		queue_fresh_acquire(1'b0);
		queue_request(OP_ACQUIRE, shadow_mount[DEPTH - 1], shadow_number[DEPTH - 1],
			6'd0, 1'b0);
		drain();

		// holds on slot 0 back to back, neither side idling
		calm = 1'b1;
		for (int k = 0; k < CALM_HOLDS; k++)
			queue_request(OP_HOLD, MOUNT_W'($urandom), {$urandom, $urandom}, 6'd0, 1'b0);
		drain();
		calm = 1'b0;
		queue_request(OP_ACQUIRE, shadow_mount[0], shadow_number[0], 6'd9, 1'b1);
		queue_request(OP_RELEASE, 8'h00, 64'h0, 6'd0, 1'b0);
		drain();

		for (int b = 0; b < BATCHES; b++) begin
			for (int k = 0; k < BATCH_SIZE; k++)
				lookup_requests.push_back(random_request());
			if (b == BATCHES / 4)
				squeeze_go = 1'b1;
			drain();
		end

		repeat (DEPTH + 8) @(negedge clk);
		if (table_answers.size() != 0) begin
			$error("%0d results never arrived", table_answers.size());
			failures++;
		end
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
